FILE: hdl/squared_correlation_engine_defines.svh
// Assertion macros for the squared correlation engine.
`ifndef SQUARED_CORRELATION_ENGINE_DEFINES_SVH
`define SQUARED_CORRELATION_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define SCE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("squared_correlation_engine: assertion failed");
`define SCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("squared_correlation_engine: assertion failed");
`else
`define SCE_ASSERT_SAME(label, ante, cons)
`define SCE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/sce_pkg.sv
package sce_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_LEN_DEF     = 4096;

  localparam int DIGIT_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int RESULT_BITS = FRAC_BITS + 1;
  localparam int STATUS_BITS = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_VAR = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_N_SAA = 3'd0,
    OP_SA_SA = 3'd1,
    OP_N_SBB = 3'd2,
    OP_SB_SB = 3'd3,
    OP_N_SAB = 3'd4,
    OP_SA_SB = 3'd5,
    OP_C_C   = 3'd6,
    OP_VA_VB = 3'd7
  } op_t;

endpackage

FILE: hdl/squared_correlation_engine.sv
// Squared Pearson correlation of a stream of sample pairs. One pair is taken per
// cycle; the front end keeps the count and the five sums, and the pair marked by
// s_tlast closes the run, whose sums go into a two-entry queue and are cleared.
// The back end turns each queued run into one result, r squared in unsigned Q1.16
// (65536 is exactly one) with status 0 ok, 1 zero variance, 2 run over MAX_LEN;
// r squared is 0 for status 1 and 2. The back end works a run through eight
// products on one shared multiplier that takes one 16-bit digit a cycle (ND digits,
// ND = ceil((2*SAMPLE_BITS+2*ceil(log2(MAX_LEN+1)))/16)) and a 17-step restoring
// divide; a zero-variance run ends after the b variance, and an over-long run skips
// both. Input stalls only while two closed runs wait in the queue.
`include "squared_correlation_engine_defines.svh"

module squared_correlation_engine #(
  parameter int SAMPLE_BITS = sce_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_LEN     = sce_pkg::MAX_LEN_DEF,
  localparam int IN_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int CNT_W      = $clog2(MAX_LEN + 1),
  localparam int SUM_W      = SAMPLE_BITS + CNT_W,
  localparam int SQ_W       = 2 * SAMPLE_BITS + CNT_W,
  localparam int SNAP_W     = 1 + CNT_W + 2 * SUM_W + 3 * SQ_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [IN_TDATA_W-1:0]           s_tdata,   // sample_a, sample_b
  input  logic                            s_tlast,   // last_sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sce_pkg::OUT_TDATA_W-1:0] m_tdata,   // r_squared
  output logic [sce_pkg::STATUS_BITS-1:0] m_tuser    // status
);

  localparam logic [sce_pkg::RESULT_BITS-1:0] R_ONE =
    sce_pkg::RESULT_BITS'(1) << sce_pkg::FRAC_BITS;

  logic                            q_push, q_full, q_pop, q_empty;
  logic [SNAP_W-1:0]               snap_in, snap_out;
  logic [sce_pkg::RESULT_BITS-1:0] r_sq;
  sce_pkg::status_t                st;

  sce_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_LEN    (MAX_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .sample_a   (s_tdata[SAMPLE_BITS-1:0]),
    .sample_b   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .last_sample(s_tlast),
    .push       (q_push),
    .snap       (snap_in),
    .full       (q_full)
  );

  sce_queue #(
    .WIDTH(SNAP_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(snap_in),
    .full (q_full),
    .pop  (q_pop),
    .rdata(snap_out),
    .empty(q_empty)
  );

  sce_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_LEN    (MAX_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_snap   (snap_out),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .r_squared(r_sq),
    .status   (st)
  );

  assign m_tdata = sce_pkg::OUT_TDATA_W'(r_sq);
  assign m_tuser = st;

  `SCE_ASSERT_SAME(a_fail_gives_zero, m_tvalid && (m_tuser != sce_pkg::ST_OK), r_sq == '0)
  `SCE_ASSERT_SAME(a_r_at_most_one, m_tvalid, r_sq <= R_ONE)
  `SCE_ASSERT_SAME(a_status_known, m_tvalid, m_tuser <= sce_pkg::ST_TOO_LONG)
  `SCE_ASSERT_NEXT(a_run_queued, s_tvalid && s_tready && s_tlast, !q_empty)

endmodule

FILE: hdl/sce_front.sv
module sce_front #(
  parameter int SAMPLE_BITS = sce_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_LEN     = sce_pkg::MAX_LEN_DEF,
  localparam int CNT_W  = $clog2(MAX_LEN + 1),
  localparam int SUM_W  = SAMPLE_BITS + CNT_W,
  localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W,
  localparam int SNAP_W = 1 + CNT_W + 2 * SUM_W + 3 * SQ_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample_a,
  input  logic [SAMPLE_BITS-1:0] sample_b,
  input  logic                   last_sample,
  output logic                   push,
  output logic [SNAP_W-1:0]      snap,
  input  logic                   full
);

  logic [CNT_W-1:0] pair_count, pair_count_next;
  logic [SUM_W-1:0] sum_first, sum_first_next;
  logic [SUM_W-1:0] sum_second, sum_second_next;
  logic [SQ_W-1:0]  sum_first_squared, sum_first_squared_next;
  logic [SQ_W-1:0]  sum_second_squared, sum_second_squared_next;
  logic [SQ_W-1:0]  sum_cross_product, sum_cross_product_next;
  logic             length_exceeded, length_exceeded_next;

  logic [2*SAMPLE_BITS-1:0] prod_aa, prod_bb, prod_ab;
  logic                     accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && last_sample;

  assign prod_aa = sample_a * sample_a;
  assign prod_bb = sample_b * sample_b;
  assign prod_ab = sample_a * sample_b;

  always_comb begin
    pair_count_next         = pair_count;
    sum_first_next          = sum_first;
    sum_second_next         = sum_second;
    sum_first_squared_next  = sum_first_squared;
    sum_second_squared_next = sum_second_squared;
    sum_cross_product_next  = sum_cross_product;
    length_exceeded_next    = length_exceeded;
    if (!length_exceeded) begin
      if (pair_count == CNT_W'(MAX_LEN)) begin
        length_exceeded_next = 1'b1;
      end else begin
        pair_count_next         = pair_count + CNT_W'(1);
        sum_first_next          = sum_first + SUM_W'(sample_a);
        sum_second_next         = sum_second + SUM_W'(sample_b);
        sum_first_squared_next  = sum_first_squared + SQ_W'(prod_aa);
        sum_second_squared_next = sum_second_squared + SQ_W'(prod_bb);
        sum_cross_product_next  = sum_cross_product + SQ_W'(prod_ab);
      end
    end
  end

  assign snap = {length_exceeded_next, sum_cross_product_next, sum_second_squared_next,
                 sum_first_squared_next, sum_second_next, sum_first_next, pair_count_next};

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pair_count         <= '0;
      sum_first          <= '0;
      sum_second         <= '0;
      sum_first_squared  <= '0;
      sum_second_squared <= '0;
      sum_cross_product  <= '0;
      length_exceeded    <= 1'b0;
    end else if (accept) begin
      pair_count         <= pair_count_next;
      sum_first          <= sum_first_next;
      sum_second         <= sum_second_next;
      sum_first_squared  <= sum_first_squared_next;
      sum_second_squared <= sum_second_squared_next;
      sum_cross_product  <= sum_cross_product_next;
      length_exceeded    <= length_exceeded_next;
    end
  end

endmodule

FILE: hdl/sce_queue.sv
module sce_queue #(
  parameter int WIDTH = 1,
  localparam int DEPTH = sce_pkg::QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: hdl/sce_mul.sv
module sce_mul #(
  parameter int OP_W = 2 * sce_pkg::DIGIT_BITS,
  localparam int DG     = sce_pkg::DIGIT_BITS,
  localparam int ND     = OP_W / DG,
  localparam int P_W    = 2 * OP_W,
  localparam int STEP_W = $clog2(ND + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] a,
  input  logic [OP_W-1:0] b,
  output logic            done,
  output logic [P_W-1:0]  product
);

  // one 16-bit digit of b per cycle, most significant first
  logic [OP_W-1:0]    a_reg, b_reg;
  logic [P_W-1:0]     acc;
  logic [STEP_W-1:0]  step;
  logic               running;
  logic [OP_W+DG-1:0] pp;

  assign pp      = a_reg * b_reg[OP_W-1 -: DG];
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(ND - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= b;
      acc   <= '0;
    end else if (running) begin
      acc   <= (acc << DG) + P_W'(pp);
      b_reg <= b_reg << DG;
    end
  end

endmodule

FILE: hdl/sce_back.sv
module sce_back #(
  parameter int SAMPLE_BITS = sce_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_LEN     = sce_pkg::MAX_LEN_DEF,
  localparam int CNT_W  = $clog2(MAX_LEN + 1),
  localparam int SUM_W  = SAMPLE_BITS + CNT_W,
  localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W,
  localparam int SNAP_W = 1 + CNT_W + 2 * SUM_W + 3 * SQ_W,
  localparam int V_W    = SQ_W + CNT_W,
  localparam int ND     = (V_W + sce_pkg::DIGIT_BITS - 1) / sce_pkg::DIGIT_BITS,
  localparam int OP_W   = ND * sce_pkg::DIGIT_BITS,
  localparam int P_W    = 2 * OP_W,
  localparam int R_W    = 2 * V_W + sce_pkg::FRAC_BITS,
  localparam int RB     = sce_pkg::RESULT_BITS,
  localparam int DCNT_W = $clog2(RB)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [SNAP_W-1:0]    q_snap,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RB-1:0]        r_squared,
  output sce_pkg::status_t     status
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state;
  sce_pkg::op_t      op, op_next;
  logic [DCNT_W-1:0] div_cnt;

  logic [CNT_W-1:0] n_r;
  logic [SUM_W-1:0] sa_r, sb_r;
  logic [SQ_W-1:0]  saa_r, sbb_r, sab_r;
  logic [V_W-1:0]   t0, va, vb, cv;
  logic [R_W-1:0]   rem, dvs, rem_next;
  logic [RB-1:0]    quo, res_r;
  sce_pkg::status_t res_st;

  logic [OP_W-1:0] mul_a, mul_b;
  logic            mul_start, mul_done;
  logic [P_W-1:0]  prod;
  logic [V_W-1:0]  prod_v, diff;
  logic            ge, zero_var, out_load;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign mul_start = (state == S_START);
  assign prod_v    = prod[V_W-1:0];
  assign diff      = (t0 >= prod_v) ? t0 - prod_v : prod_v - t0;
  assign zero_var  = (va == '0) || (diff == '0);
  assign ge        = (rem >= dvs);
  assign rem_next  = ge ? rem - dvs : rem;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    case (op)
      sce_pkg::OP_N_SAA: begin
        mul_a = OP_W'(n_r);
        mul_b = OP_W'(saa_r);
        op_next = sce_pkg::OP_SA_SA;
      end
      sce_pkg::OP_SA_SA: begin
        mul_a = OP_W'(sa_r);
        mul_b = OP_W'(sa_r);
        op_next = sce_pkg::OP_N_SBB;
      end
      sce_pkg::OP_N_SBB: begin
        mul_a = OP_W'(n_r);
        mul_b = OP_W'(sbb_r);
        op_next = sce_pkg::OP_SB_SB;
      end
      sce_pkg::OP_SB_SB: begin
        mul_a = OP_W'(sb_r);
        mul_b = OP_W'(sb_r);
        op_next = sce_pkg::OP_N_SAB;
      end
      sce_pkg::OP_N_SAB: begin
        mul_a = OP_W'(n_r);
        mul_b = OP_W'(sab_r);
        op_next = sce_pkg::OP_SA_SB;
      end
      sce_pkg::OP_SA_SB: begin
        mul_a = OP_W'(sa_r);
        mul_b = OP_W'(sb_r);
        op_next = sce_pkg::OP_C_C;
      end
      sce_pkg::OP_C_C: begin
        mul_a = OP_W'(cv);
        mul_b = OP_W'(cv);
        op_next = sce_pkg::OP_VA_VB;
      end
      sce_pkg::OP_VA_VB: begin
        mul_a = OP_W'(va);
        mul_b = OP_W'(vb);
        op_next = sce_pkg::OP_N_SAA;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        op_next = sce_pkg::OP_N_SAA;
      end
    endcase
  end

  sce_mul #(
    .OP_W(OP_W)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .product(prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= sce_pkg::OP_N_SAA;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          op <= sce_pkg::OP_N_SAA;
          if (!q_empty) begin
            state <= q_snap[SNAP_W-1] ? S_DONE : S_START;
          end
        end
        S_START: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            op <= op_next;
            if (op == sce_pkg::OP_SB_SB && zero_var) begin
              state <= S_DONE;
            end else if (op == sce_pkg::OP_VA_VB) begin
              div_cnt <= '0;
              state   <= S_DIV;
            end else begin
              state <= S_START;
            end
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(RB - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      n_r    <= q_snap[CNT_W-1:0];
      sa_r   <= q_snap[CNT_W +: SUM_W];
      sb_r   <= q_snap[CNT_W+SUM_W +: SUM_W];
      saa_r  <= q_snap[CNT_W+2*SUM_W +: SQ_W];
      sbb_r  <= q_snap[CNT_W+2*SUM_W+SQ_W +: SQ_W];
      sab_r  <= q_snap[CNT_W+2*SUM_W+2*SQ_W +: SQ_W];
      res_r  <= '0;
      res_st <= q_snap[SNAP_W-1] ? sce_pkg::ST_TOO_LONG : sce_pkg::ST_OK;
    end
    if (state == S_MUL && mul_done) begin
      case (op)
        sce_pkg::OP_N_SAA, sce_pkg::OP_N_SBB, sce_pkg::OP_N_SAB: begin
          t0 <= prod_v;
        end
        sce_pkg::OP_SA_SA: begin
          va <= diff;
        end
        sce_pkg::OP_SB_SB: begin
          vb <= diff;
          if (zero_var) begin
            res_st <= sce_pkg::ST_ZERO_VAR;
          end
        end
        sce_pkg::OP_SA_SB: begin
          cv <= diff;
        end
        sce_pkg::OP_C_C: begin
          rem <= R_W'(prod[2*V_W-1:0]) << sce_pkg::FRAC_BITS;
        end
        sce_pkg::OP_VA_VB: begin
          dvs <= R_W'(prod[2*V_W-1:0]) << sce_pkg::FRAC_BITS;
        end
        default: begin
          t0 <= t0;
        end
      endcase
    end
    if (state == S_DIV) begin
      rem <= rem_next;
      dvs <= dvs >> 1;
      quo <= {quo[RB-2:0], ge};
      if (div_cnt == DCNT_W'(RB - 1)) begin
        res_r <= {quo[RB-2:0], ge};
      end
    end
    if (out_load) begin
      r_squared <= res_r;
      status    <= res_st;
    end
  end

endmodule
